// ===== sv/fds_pkg.sv =====
`timescale 1ns / 1ps

package fds_pkg;

  // time values are unsigned 16.16 fixed point
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // item kinds carried on tuser
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COUNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd1;

  typedef struct packed {
    logic               overrun;
    logic               finished;
    logic [TIME_W-1:0]  frame_time;
    logic [INDEX_W-1:0] frame_index;
  } fds_result_t;

endpackage

// ===== sv/fds_dur_mem.sv =====
`timescale 1ns / 1ps

module fds_dur_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fds_pkg::TIME_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [fds_pkg::TIME_W-1:0] rd_data
);
  import fds_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/fds_seq_core.sv =====
`timescale 1ns / 1ps

module fds_seq_core #(
  parameter int FRAMES       = 64,
  parameter int MAX_ADVANCES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fds_pkg::MODE_W-1:0]   mode,
  input  logic [fds_pkg::SLOT_W-1:0]   frame_slot,
  input  logic [fds_pkg::TIME_W-1:0]   time_value,
  input  logic [fds_pkg::COUNT_W-1:0]  frame_count,
  input  logic                         loop_enable,
  input  logic                         out_free,
  output logic                         idle,
  output logic                         res_valid,
  output fds_pkg::fds_result_t         result
);
  import fds_pkg::*;

  localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW  = ($clog2(FRAMES + 1) > COUNT_W) ? $clog2(FRAMES + 1) : COUNT_W;
  localparam int SW  = $clog2(MAX_ADVANCES + 1);
  localparam int SXW = FW + SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [FW-1:0]       cur, cur_next;
  logic [TIME_W-1:0]   tif, tif_next;
  logic [SW-1:0]       steps, steps_next;
  logic                over, over_next;

  logic [CW-1:0]       cnt;
  logic [FW-1:0]       cur_start;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   sum_sat;
  logic [TIME_W-1:0]   dur;
  logic [TIME_W-1:0]   tif_sub;
  logic                wr_en;
  logic [SXW-1:0]      slot_ext;
  logic [FW-1:0]       rd_addr;
  logic [FW+INDEX_W-1:0] idx_ext;

  fds_dur_mem #(
    .DEPTH (FRAMES),
    .AW    (FW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ext[FW-1:0]),
    .wr_data (time_value),
    .rd_addr (rd_addr),
    .rd_data (dur)
  );

  // frames in use, clamped to the table depth
  assign cnt = (CW'(frame_count) > CW'(FRAMES)) ? CW'(FRAMES) : CW'(frame_count);
  assign cur_start = (CW'(cur) >= cnt) ? '0 : cur;
  assign sum       = {1'b0, tif} + {1'b0, time_value};
  assign sum_sat   = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign tif_sub   = tif - dur;
  assign slot_ext  = {{FW{1'b0}}, frame_slot};
  assign idle      = (state == S_IDLE);

  assign wr_en = start && (mode == MODE_LOAD) && (slot_ext < SXW'(FRAMES));

  always_comb begin
    state_next = state;
    cur_next   = cur;
    tif_next   = tif;
    steps_next = steps;
    over_next  = over;
    rd_addr    = cur;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          over_next  = 1'b0;
          steps_next = '0;
          state_next = S_OUT;
          if (mode == MODE_RESTART) begin
            cur_next = '0;
            tif_next = '0;
          end else if (mode == MODE_TICK && cnt != '0) begin
            cur_next   = cur_start;
            tif_next   = sum_sat;
            rd_addr    = cur_start;
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        // dur holds the duration of cur
        if (tif >= dur) begin
          if (steps == SW'(MAX_ADVANCES)) begin
            tif_next   = '0;
            over_next  = 1'b1;
            state_next = S_OUT;
          end else begin
            steps_next = steps + SW'(1);
            if (CW'(cur) + CW'(1) < cnt) begin
              cur_next = cur + FW'(1);
              tif_next = tif_sub;
              rd_addr  = cur + FW'(1);
            end else if (loop_enable) begin
              cur_next = '0;
              tif_next = tif_sub;
              rd_addr  = '0;
            end else begin
              tif_next   = '0;
              state_next = S_OUT;
            end
          end
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idx_ext            = {{INDEX_W{1'b0}}, cur};
  assign result.frame_index = idx_ext[INDEX_W-1:0];
  assign result.frame_time  = tif;
  assign result.finished    = !loop_enable && (cnt != '0) && (CW'(cur) == cnt - CW'(1));
  assign result.overrun     = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      tif   <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      tif   <= tif_next;
    end
    steps <= steps_next;
    over  <= over_next;
  end

endmodule

// ===== sv/frame_duration_sequencer.sv =====
`timescale 1ns / 1ps
// Throughput: one item at a time. A load, restart, idle-mode item or a tick with no clip goes
//   straight to the output state; a tick steps through the frames, one table read and subtract
//   per frame, until it stops on a frame, on the held last frame or at the MAX_ADVANCES cap;
//   bounded by the single read port of the duration table.
// Output: the result is registered into the m_axis output register when the core emits it.
// Reset (rst, sync, active high): frame 0, time 0, frame_count 0, loop_enable 1, no result
//   pending. The duration table is not cleared; entries read before written are undefined.

module frame_duration_sequencer #(
  parameter int FRAMES       = 64,
  parameter int MAX_ADVANCES = 256
) (
  input  logic                            clk,
  input  logic                            rst,

  // input transactions
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,   // frame_slot[5:0], time_value[37:6]
  input  logic [fds_pkg::MODE_W-1:0]      s_axis_tuser,   // mode[1:0]

  // result transactions
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // frame_index[5:0], frame_time[37:6],
                                                          // finished[38], overrun[39]

  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fds_pkg::*;

  logic [COUNT_W-1:0] frame_count;
  logic               loop_enable;

  logic               core_idle;
  logic               res_valid;
  fds_result_t        core_res;
  fds_result_t        out_res;
  logic               out_free;
  logic               start;

  // config writes are taken outside reset and land at once; the host must write only while
  // no item is in flight, which the block itself does not enforce
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      loop_enable <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT: frame_count <= cfg_data[COUNT_W-1:0];
        CFG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the core takes a new item whenever it is idle, even with a result still waiting below
  assign s_axis_tready = core_idle && !rst;
  assign start         = s_axis_tvalid && s_axis_tready;

  fds_seq_core #(
    .FRAMES       (FRAMES),
    .MAX_ADVANCES (MAX_ADVANCES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (s_axis_tuser),
    .frame_slot  (s_axis_tdata[SLOT_W-1:0]),
    .time_value  (s_axis_tdata[SLOT_W+TIME_W-1:SLOT_W]),
    .frame_count (frame_count),
    .loop_enable (loop_enable),
    .out_free    (out_free),
    .idle        (core_idle),
    .res_valid   (res_valid),
    .result      (core_res)
  );

  // output register: separates the result channel from the sequencer
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {out_res.overrun, out_res.finished, out_res.frame_time,
                         out_res.frame_index};

endmodule
